FILE: hw/rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the LRU key/value cache
// Request and response words, command codes, register widths and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkv_pkg;

	localparam int unsigned DATA_W          = 32;
	localparam int unsigned CAP_W           = 5;
	localparam int unsigned MAX_ENTRIES_DEF = 16;

	localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
	localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_SET = 1'b1;

	typedef struct packed {
		logic                     cmd;
		logic signed [DATA_W-1:0] lookup_key;
		logic signed [DATA_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic                     found;
		logic signed [DATA_W-1:0] read_value;
	} rsp_t;

endpackage

FILE: hw/rtl/lkv_slot_array.sv
// ----------------------------------------------------------------------------
// lkv_slot_array: entry storage with parallel tag match and age update
// Holds keys, values, valid bits and LRU ages; resolves hit, free slot and
// victim for one word and updates all entries at the next edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkv_slot_array #(
	parameter int unsigned MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       op_valid,
	input  lkv_pkg::req_t              op,
	input  logic [lkv_pkg::CAP_W-1:0]  capacity,
	output logic                       hit,
	output logic [lkv_pkg::DATA_W-1:0] hit_value
);
	import lkv_pkg::*;

	localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned AGE_W = IDX_W;
	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [DATA_W-1:0]      key_q   [MAX_ENTRIES];
	logic [DATA_W-1:0]      value_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [AGE_W-1:0]       age_q   [MAX_ENTRIES];
	logic [CNT_W-1:0]       occ_q;

	logic [MAX_ENTRIES-1:0] valid_d;
	logic [AGE_W-1:0]       age_d   [MAX_ENTRIES];
	logic [CNT_W-1:0]       occ_d;

	logic [IDX_W-1:0] hit_idx;
	logic [IDX_W-1:0] free_idx;
	logic [IDX_W-1:0] victim_idx;
	logic [IDX_W-1:0] ins_idx;
	logic             have_free;
	logic             have_victim;
	logic             room;
	logic             use_free;
	logic [AGE_W-1:0] hit_age;
	logic [CNT_W-1:0] occ_m1;
	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] eff_cap;
	logic             ins_en;

	// lookup: lowest matching slot, lowest free slot, oldest slot
	always_comb begin
		hit         = 1'b0;
		hit_idx     = '0;
		have_free   = 1'b0;
		free_idx    = '0;
		have_victim = 1'b0;
		victim_idx  = '0;
		occ_m1      = occ_q - 1'b1;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (!hit && valid_q[i] && (key_q[i] == op.lookup_key)) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!have_free && !valid_q[i]) begin
				have_free = 1'b1;
				free_idx  = IDX_W'(i);
			end
			if (!have_victim && valid_q[i] && (CNT_W'(age_q[i]) == occ_m1)) begin
				have_victim = 1'b1;
				victim_idx  = IDX_W'(i);
			end
		end
	end

	assign cap_ext   = CMP_W'(capacity);
	assign eff_cap   = (capacity == '0) ? CMP_W'(1) :
	                   ((cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext);
	assign room      = CMP_W'(occ_q) < eff_cap;
	assign use_free  = room && have_free;
	assign hit_age   = age_q[hit_idx];
	assign hit_value = value_q[hit_idx];
	assign ins_en    = op_valid && (op.cmd == CMD_SET) && !hit;
	assign ins_idx   = use_free ? free_idx : (have_victim ? victim_idx : '0);

	// next valid, age and occupancy
	always_comb begin
		valid_d = valid_q;
		occ_d   = occ_q;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			age_d[i] = age_q[i];
		end
		if (op_valid && (op.cmd == CMD_GET) && hit) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (IDX_W'(i) == hit_idx) begin
					age_d[i] = '0;
				end else if (valid_q[i] && (age_q[i] < hit_age)) begin
					age_d[i] = age_q[i] + 1'b1;
				end
			end
		end else if (ins_en) begin
			if (use_free) begin
				occ_d = occ_q + 1'b1;
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (valid_q[i]) begin
						age_d[i] = age_q[i] + 1'b1;
					end
				end
			end else if (have_victim) begin
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (valid_q[i] && (CNT_W'(age_q[i]) < occ_m1)) begin
						age_d[i] = age_q[i] + 1'b1;
					end
				end
			end else begin
				occ_d = CNT_W'(1);
			end
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (IDX_W'(i) == ins_idx) begin
					age_d[i]   = '0;
					valid_d[i] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			valid_q <= valid_d;
			occ_q   <= occ_d;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				age_q[i] <= age_d[i];
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (ins_en) begin
			key_q[ins_idx]   <= op.lookup_key;
			value_q[ins_idx] <= op.write_value;
		end else if (op_valid && (op.cmd == CMD_SET) && hit) begin
			value_q[hit_idx] <= op.write_value;
		end
	end

endmodule

FILE: hw/rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache with LRU replacement
// Get and set commands against up to MAX_ENTRIES entries, limited by capacity.
// ----------------------------------------------------------------------------
// One command word is taken in every cycle; busy is never asserted. Each word
// gives one response word on rsp, flagged by done for a single cycle. The word
// is held in the request register, then the parallel tag match and age update
// against all entries is written from it into the response register. The
// receiver cannot stall, so done must be captured when it is
// high. Write capacity with cfg_we only while no command is in flight.
`timescale 1ns / 1ps

module lru_key_value_cache #(
	parameter int unsigned MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  lkv_pkg::req_t             req,
	output logic                      done,
	output lkv_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata
);
	import lkv_pkg::*;

	logic [CAP_W-1:0]  cap_q;
	logic              valid_s1;
	req_t              req_s1;
	logic              done_s2;
	rsp_t              rsp_s2;
	logic              hit;
	logic [DATA_W-1:0] hit_value;
	rsp_t              rsp_d;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RESET;
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			valid_s1 <= start && !busy;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
		if (valid_s1) begin
			rsp_s2 <= rsp_d;
		end
	end

	lkv_slot_array #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_slots (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (valid_s1),
		.op       (req_s1),
		.capacity (cap_q),
		.hit      (hit),
		.hit_value(hit_value)
	);

	always_comb begin
		rsp_d.found = hit;
		if (req_s1.cmd == CMD_GET) begin
			rsp_d.read_value = hit ? hit_value : MISS_VALUE;
		end else begin
			rsp_d.read_value = '0;
		end
	end

	assign done = done_s2;
	assign rsp  = rsp_s2;

endmodule

FILE: hw/rtl/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker: port-level checks for the LRU key/value cache
// Response timing and response values that follow from the command alone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkv_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input lkv_pkg::req_t req,
	input logic          done,
	input lkv_pkg::rsp_t rsp
);
	import lkv_pkg::*;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy asserted");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("no response two cycles after command");

	a_done_caused: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("response without command");

	a_get_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.found && ($past(req.cmd, 2) == CMD_GET)) |->
		(rsp.read_value == MISS_VALUE))
		else $error("get miss did not return -1");

	a_set_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(req.cmd, 2) == CMD_SET)) |-> (rsp.read_value == '0))
		else $error("set returned nonzero word");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);
